FILE: hdl/tcd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcd_pkg: shared constants and types for the signed binary to decimal unit
// Widths, ASCII codes and the control bundle between sequencer and datapath.
// ----------------------------------------------------------------------------
package tcd_pkg;

	// Width of the converted two's-complement value (8..128)
	localparam int VALUE_BITS     = 128;
	// Number of BCD digits kept (3..39); higher digits wrap away
	localparam int DECIMAL_DIGITS = 39;

	localparam int HALF_BITS = 64;
	localparam int WORD_BITS = 2 * HALF_BITS;
	localparam int BCD_BITS  = 4 * DECIMAL_DIGITS;
	localparam int STEP_W    = $clog2(VALUE_BITS + 1);
	localparam int DIGIT_W   = $clog2(DECIMAL_DIGITS + 1);

	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	// Commands from the sequencer to the digit datapath
	typedef struct packed {
		logic load;         // capture magnitude, clear digits
		logic step;         // one double dabble iteration
		logic shift_digit;  // drop the top digit, move the rest up
	} tcd_ctrl_t;

endpackage : tcd_pkg
`default_nettype wire

FILE: hdl/twos_complement_to_decimal_128_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twos_complement_to_decimal_128_unit: signed 128-bit binary to ASCII decimal
// Converts one two's-complement value to its decimal text, one character per
// output transaction, by double dabble on a single shared digit row.
// ----------------------------------------------------------------------------
// One input transaction carries a 128-bit two's-complement value as two
// 64-bit halves. The unit answers with its decimal text, most significant
// character first: a '-' for negative values, then the digits with leading
// zeros dropped (zero gives a single '0'); last_char marks the final digit.
// The most negative value prints as its full magnitude. A conversion first
// captures and negates the value, then runs VALUE_BITS (128) double dabble
// steps through the single BCD digit row, skips leading zeros, sends the sign
// if negative and then the digits one per cycle while the consumer is ready.
// in_ready is high only while the unit is idle; the final character waits in
// the output register, so the next value can be taken while it is still
// pending.
module twos_complement_to_decimal_128_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [tcd_pkg::HALF_BITS-1:0] value_high,
	input  wire logic [tcd_pkg::HALF_BITS-1:0] value_low,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [7:0]                         text_char,
	output logic                               last_char
);

	// Sequencer state codes
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DABBLE = 3'd1;
	localparam logic [2:0] S_SKIP   = 3'd2;
	localparam logic [2:0] S_SIGN   = 3'd3;
	localparam logic [2:0] S_EMIT   = 3'd4;

	logic [2:0]                   state_q;
	logic [tcd_pkg::STEP_W-1:0]   step_cnt_q;
	logic [tcd_pkg::DIGIT_W-1:0]  digit_cnt_q;
	logic                         neg_q;
	logic                         out_valid_q;
	logic [7:0]                   text_char_q;
	logic                         last_char_q;

	tcd_pkg::tcd_ctrl_t           ctrl;
	logic                         in_accept;
	logic                         out_free;
	logic                         negative;
	logic [3:0]                   top_digit;
	logic                         skip_zero;

	assign in_ready  = (state_q == S_IDLE);
	assign in_accept = in_valid && in_ready;
	// Output slot is free when empty or being drained this cycle
	assign out_free  = !out_valid_q || out_ready;
	// Drop a leading zero as long as more than one digit remains
	assign skip_zero = (top_digit == 4'd0) && (digit_cnt_q > tcd_pkg::DIGIT_W'(1));

	always_comb begin
		ctrl.load        = in_accept;
		ctrl.step        = (state_q == S_DABBLE);
		ctrl.shift_digit = ((state_q == S_SKIP) && skip_zero) ||
		                   ((state_q == S_EMIT) && out_free);
	end

	tcd_dabble u_dabble (
		.clk        (clk),
		.ctrl       (ctrl),
		.value_word ({value_high, value_low}),
		.negative   (negative),
		.top_digit  (top_digit)
	);

	// Sequencer: capture, dabble, skip leading zeros, sign, digits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_cnt_q  <= '0;
			digit_cnt_q <= '0;
			neg_q       <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						neg_q      <= negative;
						step_cnt_q <= tcd_pkg::STEP_W'(tcd_pkg::VALUE_BITS);
						state_q    <= S_DABBLE;
					end
				end
				S_DABBLE: begin
					step_cnt_q <= step_cnt_q - tcd_pkg::STEP_W'(1);
					if (step_cnt_q == tcd_pkg::STEP_W'(1)) begin
						digit_cnt_q <= tcd_pkg::DIGIT_W'(tcd_pkg::DECIMAL_DIGITS);
						state_q     <= S_SKIP;
					end
				end
				S_SKIP: begin
					if (skip_zero) begin
						digit_cnt_q <= digit_cnt_q - tcd_pkg::DIGIT_W'(1);
					end else begin
						state_q <= neg_q ? S_SIGN : S_EMIT;
					end
				end
				S_SIGN: begin
					if (out_free) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						digit_cnt_q <= digit_cnt_q - tcd_pkg::DIGIT_W'(1);
						if (digit_cnt_q == tcd_pkg::DIGIT_W'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register: hold a character until the consumer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_SIGN || state_q == S_EMIT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SIGN && out_free) begin
			text_char_q <= tcd_pkg::CHAR_MINUS;
			last_char_q <= 1'b0;
		end else if (state_q == S_EMIT && out_free) begin
			text_char_q <= tcd_pkg::CHAR_ZERO + {4'd0, top_digit};
			last_char_q <= (digit_cnt_q == tcd_pkg::DIGIT_W'(1));
		end
	end

	assign out_valid = out_valid_q;
	assign text_char = text_char_q;
	assign last_char = last_char_q;

	// A new transaction always starts a full dabble pass
	a_start_dabble: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> (state_q == S_DABBLE) &&
		(step_cnt_q == tcd_pkg::STEP_W'(tcd_pkg::VALUE_BITS)))
		else $error("dabble pass not started after accept");

	// Every emitted character is a minus sign or a decimal digit
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (text_char == tcd_pkg::CHAR_MINUS) ||
		((text_char >= tcd_pkg::CHAR_ZERO) && (text_char <= tcd_pkg::CHAR_NINE)))
		else $error("character outside decimal text set");

	// The sign is never the last character of a number
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (text_char == tcd_pkg::CHAR_MINUS)) |-> !last_char)
		else $error("minus sign marked as last character");

	// Digits remain to be sent whenever the sign or emit phase is active
	a_emit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT || state_q == S_SIGN) |-> (digit_cnt_q != '0))
		else $error("emit phase with no digits left");

	// Input is refused throughout the dabble phase
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DABBLE) |-> !in_ready)
		else $error("ready raised during conversion");

endmodule : twos_complement_to_decimal_128_unit
`default_nettype wire

FILE: hdl/tcd_dabble.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcd_dabble: magnitude shift register and BCD digit row
// Takes the magnitude of the input value, runs one dabble iteration per step
// and presents the most significant digit for emission.
// ----------------------------------------------------------------------------
module tcd_dabble (
	input  wire logic                          clk,
	input  wire tcd_pkg::tcd_ctrl_t            ctrl,
	input  wire logic [tcd_pkg::WORD_BITS-1:0] value_word,
	output logic                               negative,
	output logic [3:0]                         top_digit
);

	logic [tcd_pkg::VALUE_BITS-1:0] value_in;
	logic [tcd_pkg::VALUE_BITS-1:0] magnitude;
	logic [tcd_pkg::VALUE_BITS-1:0] mag_q;
	logic [tcd_pkg::BCD_BITS-1:0]   bcd_q;
	logic [tcd_pkg::BCD_BITS-1:0]   bcd_adj;

	assign value_in = value_word[tcd_pkg::VALUE_BITS-1:0];
	assign negative = value_in[tcd_pkg::VALUE_BITS-1];

	// Subtract one, then invert
	assign magnitude = negative ? ~(value_in - tcd_pkg::VALUE_BITS'(1)) : value_in;

	// Add 3 to every digit of 5 or more
	always_comb begin
		for (int k = 0; k < tcd_pkg::DECIMAL_DIGITS; k++) begin
			if (bcd_q[4*k +: 4] >= 4'd5) begin
				bcd_adj[4*k +: 4] = bcd_q[4*k +: 4] + 4'd3;
			end else begin
				bcd_adj[4*k +: 4] = bcd_q[4*k +: 4];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			mag_q <= magnitude;
			bcd_q <= '0;
		end else if (ctrl.step) begin
			mag_q <= {mag_q[tcd_pkg::VALUE_BITS-2:0], 1'b0};
			bcd_q <= {bcd_adj[tcd_pkg::BCD_BITS-2:0], mag_q[tcd_pkg::VALUE_BITS-1]};
		end else if (ctrl.shift_digit) begin
			bcd_q <= {bcd_q[tcd_pkg::BCD_BITS-5:0], 4'd0};
		end
	end

	assign top_digit = bcd_q[tcd_pkg::BCD_BITS-1 -: 4];

endmodule : tcd_dabble
`default_nettype wire
